// ===== rtl/core/rgbc_pkg.sv =====
// Shared types, constants and kernel arithmetic for the 3x3 RGB filter.
// No dependencies; every other file of the filter but rgbc_ram imports this package.
`timescale 1ns / 1ps

package rgbc_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WEFF_W    = $clog2(MAX_WIDTH + 1);
	localparam int PEND_W    = $clog2(MAX_WIDTH + 2);

	// Field and register widths
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 16;
	localparam int CHAN_W   = 8;
	localparam int PIX_W    = 3 * CHAN_W;
	localparam int LINE_W   = 2 * PIX_W;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Kernel sum range: -1020..4080 fits signed 13 bits
	localparam int SUM_W = 13;

	// floor(x/9) as (x * ceil(2^16/9)) >> 16, exact for x below 32768
	localparam int BOX_SHIFT = 16;
	localparam int BOX_MUL   = ((1 << BOX_SHIFT) + 8) / 9;
	localparam int PROD_W    = 25;

	// Register indexes on paddr[3:2]
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KSEL   = 2'd2;

	// Input word commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		KER_BOX   = 2'd0,
		KER_GAUSS = 2'd1,
		KER_SOBX  = 2'd2,
		KER_SOBY  = 2'd3
	} kernel_t;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PIX_W-1:0]  pix_t;
	typedef pix_t [2:0][2:0]   window_t;  // [row, 0 oldest][column, 0 oldest]
	typedef chan_t [8:0]       taps_t;

	// Per-word result decision, made at acceptance
	typedef struct packed {
		logic emit;
		logic interior;
		logic done;
	} tag_t;

	// Weighted sum of the nine taps of one channel
	function automatic logic signed [SUM_W-1:0] kernel_sum(input taps_t t, input kernel_t k);
		logic signed [SUM_W-1:0] v [9];
		logic signed [SUM_W-1:0] s;
		for (int i = 0; i < 9; i++) begin
			v[i] = $signed(SUM_W'(t[i]));
		end
		case (k)
			KER_BOX: begin
				s = v[0] + v[1] + v[2] + v[3] + v[4] + v[5] + v[6] + v[7] + v[8];
			end
			KER_GAUSS: begin
				s = v[0] + v[2] + v[6] + v[8] + ((v[1] + v[3] + v[5] + v[7]) <<< 1)
					+ (v[4] <<< 2);
			end
			KER_SOBX: begin
				s = (v[6] + (v[7] <<< 1) + v[8]) - (v[0] + (v[1] <<< 1) + v[2]);
			end
			KER_SOBY: begin
				s = (v[2] + (v[5] <<< 1) + v[8]) - (v[0] + (v[3] <<< 1) + v[6]);
			end
			default: begin
				s = '0;
			end
		endcase
		return s;
	endfunction

	// Scale or clamp a kernel sum to one output channel
	function automatic chan_t kernel_scale(input logic signed [SUM_W-1:0] s, input kernel_t k);
		logic [PROD_W-1:0] prod;
		chan_t r;
		prod = PROD_W'(s[SUM_W-2:0]) * PROD_W'(BOX_MUL);
		case (k)
			KER_BOX: begin
				r = prod[BOX_SHIFT +: CHAN_W];
			end
			KER_GAUSS: begin
				r = s[4 +: CHAN_W];
			end
			default: begin
				if (s < 0) begin
					r = '0;
				end else if (s > 255) begin
					r = '1;
				end else begin
					r = s[CHAN_W-1:0];
				end
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/rgb_conv3x3_filter.sv =====
// Top level of the 3x3 RGB convolution filter.
// Depends on rgbc_pkg, rgbc_ctrl, rgbc_window, rgbc_filter.
//
// The filter takes one word per clock, pixels in raster order or drain ticks,
// and returns at most one result word per input word; a stalled result port
// holds the pipeline but never drops a word. The result for pixel k is released
// by the arrival of pixel k+W+1 (W the effective width) and reaches the output
// after that releasing word is taken, having passed a line store read stage,
// the window stage, a kernel sum stage and the result register. The line store
// is one 2048 x 48-bit RAM holding the two previous rows, read and rewritten
// once per pixel; there is no clearing pass after reset, as unwritten entries
// only reach border results, which are forced to zero. Drain ticks flush owed
// results, one per tick, and return the stream to the first pixel of a new
// image. Write the registers only while the filter is idle; a write of the
// width or height restarts the image.
`timescale 1ns / 1ps

module rgb_conv3x3_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rgbc_pkg::ADDR_W-1:0] paddr,
	input  logic [rgbc_pkg::DATA_W-1:0] pwdata,
	output logic [rgbc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_blue,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_red,
	output logic                        image_done
);

	import rgbc_pkg::*;

	logic             acc;
	logic [COL_W-1:0] rd_col;
	tag_t             tag;
	kernel_t          kernel;
	logic             s1_free;
	logic             s2_free;
	logic             s2_valid;
	tag_t             s2_tag;
	window_t          win;

	// Accept a word whenever the read stage can move
	assign in_ready = s1_free;
	assign acc      = in_valid && in_ready;

	rgbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.acc    (acc),
		.cmd    (command),
		.rd_col (rd_col),
		.tag    (tag),
		.kernel (kernel)
	);

	rgbc_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.cmd     (command),
		.px      ({red, green, blue}),
		.rd_col  (rd_col),
		.tag     (tag),
		.s2_free (s2_free),
		.s1_free (s1_free),
		.s2_valid(s2_valid),
		.s2_tag  (s2_tag),
		.win     (win)
	);

	rgbc_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_valid  (s2_valid),
		.s2_tag    (s2_tag),
		.win       (win),
		.kernel    (kernel),
		.s2_free   (s2_free),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.image_done(image_done)
	);

endmodule

// ===== rtl/core/rgbc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rgbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/rgbc_ctrl.sv =====
// Configuration registers, APB access and stream position counters.
// Decides at acceptance whether a word releases a result. Depends on rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rgbc_pkg::ADDR_W-1:0] paddr,
	input  logic [rgbc_pkg::DATA_W-1:0] pwdata,
	output logic [rgbc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       acc,
	input  logic                       cmd,
	output logic [rgbc_pkg::COL_W-1:0] rd_col,
	output rgbc_pkg::tag_t             tag,
	output rgbc_pkg::kernel_t          kernel
);

	import rgbc_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	kernel_t             ksel_q;
	logic [COL_W-1:0]    col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [COL_W-1:0]    ocol_q;
	logic [HEIGHT_W-1:0] orow_q;
	logic [PEND_W-1:0]   pend_q;

	logic [WEFF_W-1:0]   w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic                wr_cyc;
	logic                restart_cfg;
	logic                col_last;
	logic                row_last;
	logic                ocol_last;
	logic                orow_last;
	logic                pend_full;
	logic                pos_interior;
	logic                out_done;

	// Effective geometry
	always_comb begin
		if (width_q == '0) begin
			w_eff = WEFF_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			w_eff = WEFF_W'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	end

	assign wr_cyc      = psel && penable && pwrite;
	assign restart_cfg = wr_cyc && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT);

	// Position compares
	assign col_last  = (WEFF_W'(col_q) == w_eff - WEFF_W'(1));
	assign row_last  = (row_q == h_eff - HEIGHT_W'(1));
	assign ocol_last = (WEFF_W'(ocol_q) == w_eff - WEFF_W'(1));
	assign orow_last = (orow_q == h_eff - HEIGHT_W'(1));
	assign out_done  = ocol_last && orow_last;
	assign pend_full = (pend_q > PEND_W'(w_eff));

	assign pos_interior = (w_eff >= WEFF_W'(3)) && (h_eff >= HEIGHT_W'(3))
		&& (orow_q != '0) && !orow_last && (ocol_q != '0) && !ocol_last;

	// Result decision for the word at the input
	always_comb begin
		if (cmd == CMD_DRAIN) begin
			tag.emit     = (pend_q != '0);
			tag.interior = 1'b0;
		end else begin
			tag.emit     = pend_full;
			tag.interior = pos_interior;
		end
		tag.done = out_done;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(640);
			height_q <= HEIGHT_W'(480);
			ksel_q   <= KER_BOX;
		end else if (wr_cyc) begin
			case (paddr[3:2])
				REG_WIDTH: begin
					width_q <= pwdata[WIDTH_W-1:0];
				end
				REG_HEIGHT: begin
					height_q <= pwdata[HEIGHT_W-1:0];
				end
				REG_KSEL: begin
					ksel_q <= kernel_t'(pwdata[1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Stream position and owed result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			pend_q <= '0;
		end else if (restart_cfg) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			pend_q <= '0;
		end else if (acc) begin
			if (cmd == CMD_DRAIN) begin
				if (pend_q <= PEND_W'(1)) begin
					col_q  <= '0;
					row_q  <= '0;
					ocol_q <= '0;
					orow_q <= '0;
					pend_q <= '0;
				end else begin
					pend_q <= pend_q - PEND_W'(1);
					if (out_done) begin
						ocol_q <= '0;
						orow_q <= '0;
					end else if (ocol_last) begin
						ocol_q <= '0;
						orow_q <= orow_q + HEIGHT_W'(1);
					end else begin
						ocol_q <= ocol_q + COL_W'(1);
					end
				end
			end else begin
				if (col_last) begin
					col_q <= '0;
					row_q <= row_last ? '0 : row_q + HEIGHT_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				if (pend_full) begin
					if (out_done) begin
						ocol_q <= '0;
						orow_q <= '0;
					end else if (ocol_last) begin
						ocol_q <= '0;
						orow_q <= orow_q + HEIGHT_W'(1);
					end else begin
						ocol_q <= ocol_q + COL_W'(1);
					end
				end else begin
					pend_q <= pend_q + PEND_W'(1);
				end
			end
		end
	end

	// Register readback
	always_comb begin
		case (paddr[3:2])
			REG_WIDTH: begin
				prdata = DATA_W'(width_q);
			end
			REG_HEIGHT: begin
				prdata = DATA_W'(height_q);
			end
			REG_KSEL: begin
				prdata = DATA_W'(ksel_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign pready = 1'b1;
	assign rd_col = col_q;
	assign kernel = ksel_q;

endmodule

// ===== rtl/core/rgbc_window.sv =====
// Line store read stage and the 3x3 window registers.
// Holds the line store RAM with write forwarding. Depends on rgbc_pkg, rgbc_ram.
`timescale 1ns / 1ps

module rgbc_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc,
	input  logic                       cmd,
	input  rgbc_pkg::pix_t             px,
	input  logic [rgbc_pkg::COL_W-1:0] rd_col,
	input  rgbc_pkg::tag_t             tag,
	input  logic                       s2_free,
	output logic                       s1_free,
	output logic                       s2_valid,
	output rgbc_pkg::tag_t             s2_tag,
	output rgbc_pkg::window_t          win
);

	import rgbc_pkg::*;

	logic              s1_valid_q;
	logic              pix_s1;
	pix_t              px_s1;
	logic [COL_W-1:0]  col_s1;
	tag_t              tag_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] fwd_line_s1;
	logic              s2_valid_q;
	tag_t              tag_s2;
	window_t           win_q;

	logic              rd_en;
	logic              wr_en;
	logic [LINE_W-1:0] rd_line;
	logic [LINE_W-1:0] line;
	logic [LINE_W-1:0] wr_line;
	logic              s1_adv;

	assign s1_adv  = s1_valid_q && s2_free;
	assign s1_free = !s1_valid_q || s2_free;

	assign rd_en   = acc && (cmd == CMD_PIXEL);
	assign wr_en   = s1_adv && pix_s1;
	assign line    = fwd_s1 ? fwd_line_s1 : rd_line;
	// upper half is two rows back, lower half one row back
	assign wr_line = {line[PIX_W-1:0], px_s1};

	rgbc_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(col_s1),
		.wr_data(wr_line),
		.rd_en  (rd_en),
		.rd_addr(rd_col),
		.rd_data(rd_line)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload; forward a column written on the same edge it is read
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1      <= (cmd == CMD_PIXEL);
			px_s1       <= px;
			col_s1      <= rd_col;
			tag_s1      <= tag;
			fwd_s1      <= wr_en && (col_s1 == rd_col);
			fwd_line_s1 <= wr_line;
		end
	end

	// Shift the window on each pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (wr_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= line[LINE_W-1:PIX_W];
			win_q[1][2] <= line[PIX_W-1:0];
			win_q[2][2] <= px_s1;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s2_valid_q <= 1'b1;
		end else if (s2_free) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tag_s2 <= tag_s1;
		end
	end

	assign s2_valid = s2_valid_q;
	assign s2_tag   = tag_s2;
	assign win      = win_q;

endmodule

// ===== rtl/core/rgbc_filter.sv =====
// Kernel sums, scaling and the result register.
// Depends on rgbc_pkg for the kernel functions.
`timescale 1ns / 1ps

module rgbc_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s2_valid,
	input  rgbc_pkg::tag_t    s2_tag,
	input  rgbc_pkg::window_t win,
	input  rgbc_pkg::kernel_t kernel,
	output logic              s2_free,
	input  logic              out_ready,
	output logic              out_valid,
	output rgbc_pkg::chan_t   out_blue,
	output rgbc_pkg::chan_t   out_green,
	output rgbc_pkg::chan_t   out_red,
	output logic              image_done
);

	import rgbc_pkg::*;

	logic                    s3_valid_q;
	logic signed [SUM_W-1:0] sum_s3 [3];
	logic                    interior_s3;
	logic                    done_s3;
	logic                    out_valid_q;
	chan_t                   out_ch_q [3];
	logic                    out_done_q;

	taps_t                   taps [3];
	logic signed [SUM_W-1:0] sum [3];
	logic                    o_free;
	logic                    s3_free;
	logic                    s3_load;

	assign o_free  = !out_valid_q || out_ready;
	assign s3_free = !s3_valid_q || o_free;
	assign s2_free = !s2_valid || !s2_tag.emit || s3_free;
	assign s3_load = s2_valid && s2_tag.emit && s3_free;

	// Gather taps per channel and sum them
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++) begin
				taps[ch][i] = win[i / 3][i % 3][ch * CHAN_W +: CHAN_W];
			end
			sum[ch] = kernel_sum(taps[ch], kernel);
		end
	end

	// Stage 3: registered sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (s3_load) begin
			s3_valid_q <= 1'b1;
		end else if (o_free) begin
			s3_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_load) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum_s3[ch] <= sum[ch];
			end
			interior_s3 <= s2_tag.interior;
			done_s3     <= s2_tag.done;
		end
	end

	// Result register; border results read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_valid_q && o_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_valid_q && o_free) begin
			for (int ch = 0; ch < 3; ch++) begin
				out_ch_q[ch] <= interior_s3 ? kernel_scale(sum_s3[ch], kernel) : '0;
			end
			out_done_q <= done_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_blue   = out_ch_q[0];
	assign out_green  = out_ch_q[1];
	assign out_red    = out_ch_q[2];
	assign image_done = out_done_q;

endmodule

// ===== rtl/core/rgbc_checker.sv =====
// Port-level assertions for the 3x3 RGB filter, bound to the top level.
// Depends on rgbc_pkg and rgb_conv3x3_filter.
`timescale 1ns / 1ps

module rgbc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [rgbc_pkg::ADDR_W-1:0] paddr,
	input logic [rgbc_pkg::DATA_W-1:0] pwdata,
	input logic [rgbc_pkg::DATA_W-1:0] prdata,
	input logic                        pready,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  out_blue,
	input logic [7:0]                  out_green,
	input logic [7:0]                  out_red,
	input logic                        image_done
);

	import rgbc_pkg::*;

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_blue) && $stable(out_green)
			&& $stable(out_red) && $stable(image_done))
		else $error("stalled result word changed");

	// The input side only stalls behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// The last result of an image sits on the border
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0)
		else $error("final result of an image is not zero");

	// A kernel select write reads back on the next cycle
	a_ksel_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[3:2] == REG_KSEL
			|=> !(psel && !pwrite && paddr[3:2] == REG_KSEL)
				|| prdata == DATA_W'($past(pwdata[1:0])))
		else $error("kernel select readback mismatch");

endmodule

bind rgb_conv3x3_filter rgbc_checker u_rgbc_checker (.*);

// ===== bench/tb_rgb_conv3x3_filter.sv =====
// Self-checking bench for the 3x3 RGB convolution filter: random and directed
// pixel streams with drain ticks, checked against a behavioral predictor.
// Depends on rgbc_pkg and rgb_conv3x3_filter.
`timescale 1ns / 1ps

module tb_rgb_conv3x3_filter;
	import rgbc_pkg::*;

	localparam int          RANDOM_WORDS   = 750;
	localparam int          MAX_GAP        = 13;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          SETTLE_CYCLES  = 12;
	localparam int          TAIL_CYCLES    = 16;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam logic [1:0]  REG_UNUSED     = 2'd3;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
		logic  done;
	} filtered_px_t;

	// Behavioral copy of the filter plus the queue of results it owes
	class filter_scoreboard;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		kernel_t             ksel;
		bit [PIX_W-1:0]      line_mem [2][MAX_WIDTH];  // [0] previous row, [1] the one before
		bit [PIX_W-1:0]      win [3][3];               // [row, 0 oldest][column, 0 oldest]
		int unsigned         col;
		int unsigned         out_idx;
		int unsigned         owed;
		filtered_px_t        expected_px [$];
		int unsigned         errors;

		function new();
			width_reg  = 12'd640;
			height_reg = 16'd480;
			ksel       = KER_BOX;
			errors     = 0;
			restart();
		endfunction

		function void restart();
			col     = 0;
			out_idx = 0;
			owed    = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int unsigned outstanding();
			return expected_px.size();
		endfunction

		// Weighted window sum of one channel, then scale or clamp
		function chan_t channel_out(int sh);
			int acc;
			int v;
			int r;
			int c;
			acc = 0;
			for (int i = 0; i < 9; i++) begin
				r = i / 3;
				c = i % 3;
				v = int'(win[r][c][sh +: CHAN_W]);
				case (ksel)
					KER_BOX:   acc += v;
					KER_GAUSS: acc += v * (r == 1 ? 2 : 1) * (c == 1 ? 2 : 1);
					KER_SOBX:  acc += v * (r - 1) * (c == 1 ? 2 : 1);
					default:   acc += v * (c - 1) * (r == 1 ? 2 : 1);
				endcase
			end
			if (ksel == KER_BOX) return chan_t'(acc / 9);
			if (ksel == KER_GAUSS) return chan_t'(acc / 16);
			if (acc < 0) return '0;
			if (acc > 255) return '1;
			return chan_t'(acc);
		endfunction

		// Queue the next result of the image; border positions and drain results give zero
		function void queue_result(bit from_window);
			int unsigned  w;
			int unsigned  h;
			int unsigned  frame;
			int unsigned  orow;
			int unsigned  ocol;
			bit           interior;
			filtered_px_t px;
			w        = eff_width();
			h        = eff_height();
			frame    = w * h;
			orow     = out_idx / w;
			ocol     = out_idx % w;
			interior = from_window && w >= 3 && h >= 3 && orow >= 1 && orow <= h - 2 &&
				ocol >= 1 && ocol <= w - 2;
			px.blue  = interior ? channel_out(0) : '0;
			px.green = interior ? channel_out(CHAN_W) : '0;
			px.red   = interior ? channel_out(2 * CHAN_W) : '0;
			px.done  = (out_idx + 1 >= frame);
			out_idx  = px.done ? 0 : out_idx + 1;
			expected_px.push_back(px);
		endfunction

		function void note_register(logic [1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_WIDTH: begin
					width_reg = val[WIDTH_W-1:0];
					restart();
				end
				REG_HEIGHT: begin
					height_reg = val[HEIGHT_W-1:0];
					restart();
				end
				REG_KSEL: begin
					ksel = kernel_t'(val[1:0]);
				end
				default: begin
				end
			endcase
		endfunction

		// Advance the predictor by one accepted input word
		function void note_word(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			bit [PIX_W-1:0] px;
			if (cmd == CMD_DRAIN) begin
				if (owed == 0) begin
					restart();
					return;
				end
				queue_result(1'b0);
				owed--;
				if (owed == 0) restart();
				return;
			end
			px = {r, g, b};
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = line_mem[1][col];
			win[1][2] = line_mem[0][col];
			win[2][2] = px;
			line_mem[1][col] = line_mem[0][col];
			line_mem[0][col] = px;
			col++;
			if (col >= eff_width()) col = 0;
			if (owed >= eff_width() + 1) queue_result(1'b1);
			else owed++;
		endfunction

		function void check_result(filtered_px_t got);
			filtered_px_t want;
			if (expected_px.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result word with none owed: b=%0d g=%0d r=%0d done=%0b",
						$time, got.blue, got.green, got.red, got.done);
				return;
			end
			want = expected_px.pop_front();
			if (got.blue != want.blue || got.green != want.green || got.red != want.red ||
					got.done != want.done) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch: expected b=%0d g=%0d r=%0d done=%0b, got b=%0d g=%0d r=%0d done=%0b",
						$time, want.blue, want.green, want.red, want.done,
						got.blue, got.green, got.red, got.done);
			end
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              command   = CMD_PIXEL;
	logic [7:0]        red       = '0;
	logic [7:0]        green     = '0;
	logic [7:0]        blue      = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        out_blue;
	logic [7:0]        out_green;
	logic [7:0]        out_red;
	logic              image_done;

	filter_scoreboard sb = new();
	bit               tx_gaps  = 1'b1;
	bit               rx_gaps  = 1'b1;
	bit               hold_req = 1'b0;
	int unsigned      words_sent = 0;

	rgb_conv3x3_filter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.image_done (image_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Setup cycle, access cycle, then release the bus
	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.note_register(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h, input kernel_t k);
		reg_write(REG_WIDTH, DATA_W'(w));
		reg_write(REG_HEIGHT, DATA_W'(h));
		reg_write(REG_KSEL, DATA_W'(k));
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one word after a random gap; hold it until taken
	task automatic send_word(input logic cmd, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_word(cmd, r, g, b);
		words_sent++;
	endtask

	task automatic send_pixels(input int unsigned n);
		repeat (n) send_word(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
	endtask

	task automatic send_drains(input int unsigned n);
		repeat (n) send_word(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Drop valid, wait out every owed result and the pipeline behind it
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: random ready gaps, one long hold on request
	initial begin : result_sink
		int unsigned  gap;
		filtered_px_t got;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.blue  = out_blue;
			got.green = out_green;
			got.red   = out_red;
			got.done  = image_done;
			sb.check_result(got);
		end
	end

	// Abort when no word moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_ready === 1'b1) ||
					(out_valid === 1'b1 && out_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned ew;
		int unsigned eh;
		int unsigned phase;
		kernel_t     k;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 3x3 image with vertical edges under Sobel Y, flush, idle drain
		set_geometry(3, 3, KER_SOBY);
		for (int i = 0; i < 9; i++)
			send_word(CMD_PIXEL, (i % 3 == 2) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
				(i >= 6) ? 8'hFF : ((i >= 3) ? 8'd100 : 8'h00));
		send_drains(4);
		send_drains(1);
		settle();
		// Unmapped register, kernel-only write, then width and height below three
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		reg_write(REG_KSEL, DATA_W'(KER_GAUSS));
		reg_write(REG_WIDTH, 32'd2);
		reg_write(REG_HEIGHT, 32'd0);
		send_pixels(4);
		send_drains(3);
		settle();

		// Width beyond the line store clamps; stream part of a row, then flush
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_geometry(4095, 3, KER_BOX);
		send_pixels(40);
		send_drains(41);
		settle();

		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			tx_gaps = $urandom_range(0, 2) != 0;
			rx_gaps = $urandom_range(0, 2) != 0;
			k = kernel_t'($urandom_range(0, 3));
			if (phase == 0) begin
				// Long receiver hold with the sender pushing flat out
				tx_gaps  = 1'b0;
				rx_gaps  = 1'b0;
				set_geometry(6, 5, KER_GAUSS);
				hold_req = 1'b1;
				send_pixels(90);
				send_drains(7);
			end else if (phase == 1) begin
				// Tallest image: stream part of it, then flush
				set_geometry(5, 65535, KER_SOBX);
				send_pixels(80);
				send_drains(6);
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					reg_write(REG_KSEL, DATA_W'(k));
				end else begin
					case ($urandom_range(0, 7))
						0:       w = 0;
						1:       w = $urandom_range(1, 2);
						default: w = $urandom_range(3, 9);
					endcase
					case ($urandom_range(0, 7))
						0:       h = 0;
						1:       h = $urandom_range(1, 2);
						default: h = $urandom_range(3, 6);
					endcase
					set_geometry(w, h, k);
				end
				ew = sb.eff_width();
				eh = sb.eff_height();
				if ($urandom_range(0, 9) < 7) begin
					// Whole images back to back, then a flush of some kind or none
					send_pixels(ew * eh * $urandom_range(1, 3));
					case ($urandom_range(0, 3))
						0: ;
						1: send_drains(ew + 1);
						2: send_drains(ew + 1 + $urandom_range(1, 3));
						default: send_drains($urandom_range(1, ew));
					endcase
				end else begin
					// Broken stream: drains sprinkled among pixels
					repeat ($urandom_range(10, 60)) begin
						if ($urandom_range(0, 3) == 0) send_drains(1);
						else send_pixels(1);
					end
				end
			end
			settle();
			phase++;
		end

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
